// ----- sv/tcsl_pkg.sv -----
// shared types and constants of the texture cache slot lookup
`timescale 1ns / 1ps

package tcsl_pkg;

    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int AGE_W   = 32;

    localparam logic [KIND_W-1:0] KIND_LOOKUP    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR_AGE = 2'd2;

    // full descriptor key, compared as one word
    typedef struct packed {
        logic [31:0] source_address;
        logic [2:0]  format;
        logic [1:0]  texel_size;
        logic [9:0]  tex_width;
        logic [9:0]  tex_height;
        logic [11:0] row_stride;
        logic [11:0] start_s;
        logic [11:0] start_t;
        logic [31:0] palette_hash;
        logic [8:0]  palette_count;
    } key_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic cmp_en;
        logic cmp_first;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic key_eq;
        logic out_free;
    } status_t;

endpackage

// ----- sv/tcsl_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps

interface tcsl_req_if import tcsl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [31:0]       source_address;
    logic [2:0]        format;
    logic [1:0]        texel_size;
    logic [9:0]        tex_width;
    logic [9:0]        tex_height;
    logic [11:0]       row_stride;
    logic [11:0]       start_s;
    logic [11:0]       start_t;
    logic [31:0]       palette_hash;
    logic [8:0]        palette_count;
    logic [3:0]        mark_slot;

    modport source (
        output valid, kind, source_address, format, texel_size, tex_width, tex_height,
               row_stride, start_s, start_t, palette_hash, palette_count, mark_slot,
        input  ready
    );
    modport sink (
        input  valid, kind, source_address, format, texel_size, tex_width, tex_height,
               row_stride, start_s, start_t, palette_hash, palette_count, mark_slot,
        output ready
    );
endinterface

interface tcsl_rsp_if import tcsl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              key_matched;

    modport source (output valid, slot, hit, key_matched, input ready);
    modport sink   (input valid, slot, hit, key_matched, output ready);
endinterface

// ----- sv/tcsl_ctrl.sv -----
// sequencer for the slot scan and the commit of each request
`timescale 1ns / 1ps

module tcsl_ctrl import tcsl_pkg::*; #(
    parameter int NUM_SLOTS = 16,
    localparam int IDX_W = $clog2(NUM_SLOTS),
    localparam int CNT_W = $clog2(NUM_SLOTS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [KIND_W-1:0] req_kind,
    output logic              req_ready,
    output cmd_t              cmd,
    output logic [IDX_W-1:0]  rd_addr,
    output logic [IDX_W-1:0]  cmp_idx,
    input  status_t           status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   rd_cnt_reg;
    logic               cmp_valid_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               rd_en;
    logic               last_cmp;
    logic               scan_done;

    always_comb
    begin
        rd_en     = (state_reg == ST_SCAN) && (rd_cnt_reg < CNT_W'(NUM_SLOTS));
        last_cmp  = (cmp_idx_reg == IDX_W'(NUM_SLOTS - 1));
        scan_done = cmp_valid_reg && (status.key_eq || last_cmp);
        rd_addr   = rd_cnt_reg[IDX_W-1:0];
        cmp_idx   = cmp_idx_reg;
        req_ready = (state_reg == ST_IDLE);

        cmd.capture   = (state_reg == ST_IDLE) && req_valid;
        cmd.rd_en     = rd_en;
        cmd.cmp_en    = (state_reg == ST_SCAN) && cmp_valid_reg;
        cmd.cmp_first = (cmp_idx_reg == '0);
        cmd.commit    = (state_reg == ST_FINISH) && status.out_free;

        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_kind == KIND_LOOKUP) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_cnt_reg    <= '0;
                    cmp_valid_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (scan_done)
                    begin
                        cmp_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        cmp_valid_reg <= rd_en;
                        cmp_idx_reg   <= rd_addr;
                        if (rd_en)
                        begin
                            rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                        end
                    end
                end
                ST_FINISH:
                begin
                    cmp_valid_reg <= 1'b0;
                end
                default:
                begin
                    cmp_valid_reg <= 1'b0;
                end
            endcase
        end
    end

    a_cmp_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == ST_SCAN))
        else $error("compare stage active outside the scan");

    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CNT_W'(NUM_SLOTS))
        else $error("read counter ran past the last slot");

    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after commit");

endmodule

// ----- sv/tcsl_dp.sv -----
// slot storage, key compare, victim tracking, age counter and result register
`timescale 1ns / 1ps

module tcsl_dp import tcsl_pkg::*; #(
    parameter int NUM_SLOTS = 16,
    localparam int IDX_W = $clog2(NUM_SLOTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic [IDX_W-1:0]  rd_addr,
    input  logic [IDX_W-1:0]  cmp_idx,
    output status_t           status,
    input  key_t              req_key,
    input  logic [KIND_W-1:0] req_kind,
    input  logic [3:0]        req_mark,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [SLOT_W-1:0] rsp_slot,
    output logic              rsp_hit,
    output logic              rsp_key_matched
);

    key_t               key_mem [NUM_SLOTS];
    logic [AGE_W-1:0]   age_mem [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] filled_reg;
    logic [NUM_SLOTS-1:0] conv_valid_reg;
    logic               filled_rd_reg;
    key_t               key_rd_reg;
    logic [AGE_W-1:0]   age_rd_reg;

    key_t               key_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [3:0]         mark_reg;
    logic               matched_reg;
    logic [IDX_W-1:0]   match_idx_reg;
    logic [IDX_W-1:0]   victim_idx_reg;
    logic [AGE_W-1:0]   victim_age_reg;
    logic [AGE_W-1:0]   age_ctr_reg;

    logic               out_valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               hit_reg;
    logic               key_matched_reg;

    key_t               key_q;
    logic [AGE_W-1:0]   age_q;
    logic [AGE_W-1:0]   age_stamp;
    logic               is_lookup;
    logic               key_we;
    logic               age_we;
    logic [IDX_W-1:0]   age_waddr;
    logic               mark_ok;
    logic [IDX_W-1:0]   mark_idx;

    // never-written slots read as the all-zero reset entry
    always_comb
    begin
        key_q     = filled_rd_reg ? key_rd_reg : '0;
        age_q     = filled_rd_reg ? age_rd_reg : '0;
        age_stamp = age_ctr_reg + AGE_W'(1);
        is_lookup = (kind_reg == KIND_LOOKUP);
        // a matched slot already holds this key, so rewriting it just marks it filled
        key_we    = cmd.commit && is_lookup;
        age_we    = cmd.commit && is_lookup;
        age_waddr = matched_reg ? match_idx_reg : victim_idx_reg;
        mark_ok   = ({28'd0, mark_reg} < 32'(NUM_SLOTS));
        mark_idx  = IDX_W'(mark_reg);

        status.key_eq   = (key_q == key_reg);
        status.out_free = !out_valid_reg || rsp_ready;

        rsp_valid       = out_valid_reg;
        rsp_slot        = slot_reg;
        rsp_hit         = hit_reg;
        rsp_key_matched = key_matched_reg;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[age_waddr] <= key_reg;
        end
        if (age_we)
        begin
            age_mem[age_waddr] <= age_stamp;
        end
        if (cmd.rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            age_rd_reg <= age_mem[rd_addr];
        end
    end

    // request capture, scan bookkeeping and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            key_reg  <= req_key;
            kind_reg <= req_kind;
            mark_reg <= req_mark;
        end
        if (cmd.cmp_en)
        begin
            if (status.key_eq)
            begin
                match_idx_reg <= cmp_idx;
            end
            if (cmd.cmp_first || key_q.source_address == '0 || age_q < victim_age_reg)
            begin
                victim_idx_reg <= cmp_idx;
                victim_age_reg <= age_q;
            end
        end
        if (cmd.commit)
        begin
            if (is_lookup && matched_reg)
            begin
                slot_reg        <= SLOT_W'(match_idx_reg);
                hit_reg         <= conv_valid_reg[match_idx_reg];
                key_matched_reg <= 1'b1;
            end
            else if (is_lookup)
            begin
                slot_reg        <= SLOT_W'(victim_idx_reg);
                hit_reg         <= 1'b0;
                key_matched_reg <= 1'b0;
            end
            else
            begin
                slot_reg        <= '0;
                hit_reg         <= 1'b0;
                key_matched_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg     <= '0;
            conv_valid_reg <= '0;
            filled_rd_reg  <= 1'b0;
            matched_reg    <= 1'b0;
            age_ctr_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                filled_rd_reg <= filled_reg[rd_addr];
            end
            if (cmd.capture)
            begin
                matched_reg <= 1'b0;
            end
            else if (cmd.cmp_en && status.key_eq)
            begin
                matched_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                unique case (kind_reg)
                    KIND_LOOKUP:
                    begin
                        age_ctr_reg           <= age_stamp;
                        filled_reg[age_waddr] <= 1'b1;
                        if (!matched_reg)
                        begin
                            conv_valid_reg[victim_idx_reg] <= 1'b0;
                        end
                    end
                    KIND_MARK:
                    begin
                        if (mark_ok)
                        begin
                            conv_valid_reg[mark_idx] <= 1'b1;
                        end
                    end
                    KIND_CLEAR_AGE:
                    begin
                        age_ctr_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_hit_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!hit_reg || key_matched_reg))
        else $error("hit reported without a key match");

    a_lookup_stamps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && kind_reg == KIND_LOOKUP) |=>
            (age_ctr_reg == $past(age_ctr_reg) + AGE_W'(1)))
        else $error("lookup did not advance the age counter");

    a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && kind_reg != KIND_LOOKUP) |=>
            (slot_reg == '0 && !hit_reg && !key_matched_reg))
        else $error("non-lookup transfer carried a nonzero result");

endmodule

// ----- sv/texture_cache_slot_lookup_top.sv -----
// top level of the texture descriptor cache slot lookup
`timescale 1ns / 1ps

// fully associative cache of NUM_SLOTS texture descriptors with age-stamp lru
// req channel: one transfer per operation; kind selects lookup, mark a slot
//   converted, or clear the age counter; mark_slot is used by the mark only
// rsp channel: one transfer per request, giving slot, hit and key_matched;
//   operations other than a lookup return all zero
// a lookup scans the slots one per cycle through the key and age memories,
//   stopping at the first key match; on a miss the oldest slot (or the last
//   slot holding a zero source address) is rewritten and left unconverted
// a lookup goes from idle through the scan to the finish state, where its result
//   is committed to the output register; other kinds go from idle straight to finish
// requests are handled one at a time, and a missing lookup scans every slot,
//   paced by the single memory read port
// reset clears the age counter and all fill and converted flags at once, so
//   every slot reads as an all-zero entry and no clearing pass is needed
// a stalled rsp holds the result in the output register; the next request
//   is still taken and scanned, and waits to commit until that register frees

module texture_cache_slot_lookup_top import tcsl_pkg::*; #(
    parameter int NUM_SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tcsl_req_if.sink      req,
    tcsl_rsp_if.source    rsp
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] cmp_idx;
    key_t             req_key;

    // pack the request fields into the compare key
    always_comb
    begin
        req_key.source_address = req.source_address;
        req_key.format         = req.format;
        req_key.texel_size     = req.texel_size;
        req_key.tex_width      = req.tex_width;
        req_key.tex_height     = req.tex_height;
        req_key.row_stride     = req.row_stride;
        req_key.start_s        = req.start_s;
        req_key.start_t        = req.start_t;
        req_key.palette_hash   = req.palette_hash;
        req_key.palette_count  = req.palette_count;
    end

    // scan sequencer
    tcsl_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .cmp_idx   (cmp_idx),
        .status    (status)
    );

    // storage, compare and result register
    tcsl_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .cmp_idx         (cmp_idx),
        .status          (status),
        .req_key         (req_key),
        .req_kind        (req.kind),
        .req_mark        (req.mark_slot),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_slot        (rsp.slot),
        .rsp_hit         (rsp.hit),
        .rsp_key_matched (rsp.key_matched)
    );

endmodule
